FILE: src/pop3_command_checker_macros.svh
// Assertion macros shared by the POP3 command checker modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef POP3_COMMAND_CHECKER_MACROS_SVH
`define POP3_COMMAND_CHECKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define POP3CC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define POP3CC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pop3cc_pkg.sv
// Package for the POP3 command checker: keyword table, codes and shared types.
// No dependencies; used by pop3cc_tracker and pop3_command_checker.
package pop3cc_pkg;

    localparam int NUM_PAT  = 22;
    localparam int TEXT_LEN = 15;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [4:0] POS_MAX = 5'd31;
    localparam logic [NUM_PAT-1:0] MASK_ALL = '1;

    // Keyword kinds
    localparam logic [1:0] KIND_BARE    = 2'd0;
    localparam logic [1:0] KIND_COUNTED = 2'd1;
    localparam logic [1:0] KIND_CHECKED = 2'd2;

    // Command codes
    localparam logic [4:0] CMD_NONE   = 5'd0;
    localparam logic [4:0] CMD_OK     = 5'd1;
    localparam logic [4:0] CMD_ERR    = 5'd2;
    localparam logic [4:0] CMD_DELE   = 5'd3;
    localparam logic [4:0] CMD_LIST   = 5'd4;
    localparam logic [4:0] CMD_RETR   = 5'd5;
    localparam logic [4:0] CMD_TOP    = 5'd6;
    localparam logic [4:0] CMD_STAT   = 5'd7;
    localparam logic [4:0] CMD_APOP   = 5'd8;
    localparam logic [4:0] CMD_NOOP   = 5'd9;
    localparam logic [4:0] CMD_QUIT   = 5'd10;
    localparam logic [4:0] CMD_RSET   = 5'd11;
    localparam logic [4:0] CMD_RST    = 5'd12;
    localparam logic [4:0] CMD_UIDL   = 5'd13;
    localparam logic [4:0] CMD_EXPIRE = 5'd14;
    localparam logic [4:0] CMD_LOGIND = 5'd15;
    localparam logic [4:0] CMD_CAPA   = 5'd16;
    localparam logic [4:0] CMD_IMPL   = 5'd17;
    localparam logic [4:0] CMD_USER   = 5'd18;
    localparam logic [4:0] CMD_PASS   = 5'd19;

    // Verdict codes
    localparam logic [2:0] VERD_OK       = 3'd0;
    localparam logic [2:0] VERD_BAD_ONE  = 3'd1;
    localparam logic [2:0] VERD_BAD_TWO  = 3'd2;
    localparam logic [2:0] VERD_TOO_FEW  = 3'd3;
    localparam logic [2:0] VERD_TOO_MANY = 3'd4;

    // Text is right-justified: the first character sits in the top used byte.
    typedef struct packed {
        logic [8*TEXT_LEN-1:0] text;
        logic [3:0]            len;
        logic [4:0]            code;
        logic [1:0]            kind;
        logic [1:0]            nargs;
        logic [1:0]            int_mask;
    } t_keyword;

    typedef struct packed {
        logic [4:0] command_code;
        logic [2:0] verdict;
        logic [1:0] token_count;
    } t_result;

    // Listed in priority order: the earliest fitting entry wins.
    localparam t_keyword KEYWORDS [NUM_PAT] = '{
        '{"+OK",                    4'd3,  CMD_OK,     KIND_BARE,    2'd0, 2'd0},
        '{"-ERR",                   4'd4,  CMD_ERR,    KIND_BARE,    2'd0, 2'd0},
        '{"DELE ",                  4'd5,  CMD_DELE,   KIND_CHECKED, 2'd1, 2'd1},
        '{"LIST\015\012",           4'd6,  CMD_LIST,   KIND_BARE,    2'd0, 2'd0},
        '{"LIST ",                  4'd5,  CMD_LIST,   KIND_CHECKED, 2'd1, 2'd1},
        '{"RETR ",                  4'd5,  CMD_RETR,   KIND_CHECKED, 2'd1, 2'd1},
        '{"TOP ",                   4'd4,  CMD_TOP,    KIND_CHECKED, 2'd2, 2'd3},
        '{"TOP",                    4'd3,  CMD_TOP,    KIND_BARE,    2'd0, 2'd0},
        '{"STAT\015\012",           4'd6,  CMD_STAT,   KIND_BARE,    2'd0, 2'd0},
        '{"APOP ",                  4'd5,  CMD_APOP,   KIND_CHECKED, 2'd2, 2'd0},
        '{"NOOP\015\012",           4'd6,  CMD_NOOP,   KIND_BARE,    2'd0, 2'd0},
        '{"QUIT\015\012",           4'd6,  CMD_QUIT,   KIND_BARE,    2'd0, 2'd0},
        '{"RSET\015\012",           4'd6,  CMD_RSET,   KIND_BARE,    2'd0, 2'd0},
        '{"RST\015\012",            4'd5,  CMD_RST,    KIND_BARE,    2'd0, 2'd0},
        '{"UIDL\015\012",           4'd6,  CMD_UIDL,   KIND_BARE,    2'd0, 2'd0},
        '{"EXPIRE NEVER\015\012",   4'd14, CMD_EXPIRE, KIND_COUNTED, 2'd1, 2'd0},
        '{"EXPIRE ",                4'd7,  CMD_EXPIRE, KIND_CHECKED, 2'd1, 2'd1},
        '{"LOGIN-DELAY ",           4'd12, CMD_LOGIND, KIND_CHECKED, 2'd1, 2'd1},
        '{"CAPA\015\012",           4'd6,  CMD_CAPA,   KIND_BARE,    2'd0, 2'd0},
        '{"IMPLEMENTATION ",        4'd15, CMD_IMPL,   KIND_CHECKED, 2'd1, 2'd0},
        '{"USER ",                  4'd5,  CMD_USER,   KIND_CHECKED, 2'd1, 2'd0},
        '{"PASS ",                  4'd5,  CMD_PASS,   KIND_CHECKED, 2'd1, 2'd0}
    };

    // Character of a keyword at a position; valid only for pos below len.
    function automatic logic [7:0] pat_byte(input t_keyword k, input logic [4:0] pos);
        logic [3:0] idx;
        idx = k.len - 4'd1 - pos[3:0];
        return k.text[{idx, 3'b000} +: 8];
    endfunction

endpackage

FILE: src/pop3cc_tracker.sv
// Per-message state of the POP3 command checker: keyword match, token split
// and digit checks. Uses pop3cc_pkg and pop3_command_checker_macros.svh.
`include "pop3_command_checker_macros.svh"

module pop3cc_tracker
    import pop3cc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_result    o_result
);

    logic [4:0]         r_pos,      n_pos;
    logic [NUM_PAT-1:0] r_mask,     n_mask;
    logic [4:0]         r_chosen,   n_chosen;
    logic               r_args_end, n_args_end;
    logic               r_inside,   n_inside;
    logic [1:0]         r_tokens,   n_tokens;
    logic               r_bad_one,  n_bad_one;
    logic               r_bad_two,  n_bad_two;

    always_comb begin
        logic [1:0] tok;
        logic [5:0] pos_inc;
        logic       found;
        tok        = r_tokens;
        pos_inc    = {1'b0, r_pos} + 6'd1;
        found      = 1'b0;
        n_pos      = r_pos;
        n_mask     = r_mask;
        n_chosen   = r_chosen;
        n_args_end = r_args_end;
        n_inside   = r_inside;
        n_tokens   = r_tokens;
        n_bad_one  = r_bad_one;
        n_bad_two  = r_bad_two;
        o_result   = '{CMD_NONE, VERD_OK, 2'd0};

        // Argument bytes: split at spaces, stop at the first CR or LF
        if (r_chosen != CMD_NONE && !r_args_end) begin
            if (i_data_byte == CHAR_CR || i_data_byte == CHAR_LF) begin
                n_args_end = 1'b1;
                n_inside   = 1'b0;
            end else if (i_data_byte == CHAR_SPACE) begin
                n_inside = 1'b0;
            end else begin
                if (!r_inside && r_tokens != 2'd3) begin
                    tok = r_tokens + 2'd1;
                end
                n_inside = 1'b1;
                n_tokens = tok;
                if (i_data_byte < CHAR_ZERO || i_data_byte > CHAR_NINE) begin
                    if (tok == 2'd1) begin
                        n_bad_one = 1'b1;
                    end else if (tok == 2'd2) begin
                        n_bad_two = 1'b1;
                    end
                end
            end
        end

        // Keyword match: drop candidates that disagree at this position
        for (int i = 0; i < NUM_PAT; i++) begin
            if (r_mask[i] && r_pos < {1'b0, KEYWORDS[i].len}) begin
                if (pat_byte(KEYWORDS[i], r_pos) != i_data_byte) begin
                    n_mask[i] = 1'b0;
                end else if (r_pos == {1'b0, KEYWORDS[i].len - 4'd1}
                             && KEYWORDS[i].kind != KIND_BARE) begin
                    n_chosen = KEYWORDS[i].code;
                end
            end
        end

        if (r_pos != POS_MAX) begin
            n_pos = r_pos + 5'd1;
        end

        // Result: earliest surviving keyword that fits inside the message
        for (int i = 0; i < NUM_PAT; i++) begin
            if (!found && n_mask[i] && {2'b00, KEYWORDS[i].len} <= pos_inc) begin
                found = 1'b1;
                o_result.command_code = KEYWORDS[i].code;
                if (KEYWORDS[i].kind != KIND_BARE) begin
                    o_result.token_count = n_tokens;
                end
                if (KEYWORDS[i].kind == KIND_CHECKED) begin
                    if (KEYWORDS[i].int_mask[0] && n_bad_one) begin
                        o_result.verdict = VERD_BAD_ONE;
                    end
                    if (KEYWORDS[i].int_mask[1] && n_bad_two) begin
                        o_result.verdict = VERD_BAD_TWO;
                    end
                    if (n_tokens < KEYWORDS[i].nargs) begin
                        o_result.verdict = VERD_TOO_FEW;
                    end else if (n_tokens > KEYWORDS[i].nargs) begin
                        o_result.verdict = VERD_TOO_MANY;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_pos      <= '0;
            r_mask     <= MASK_ALL;
            r_chosen   <= CMD_NONE;
            r_args_end <= 1'b0;
            r_inside   <= 1'b0;
            r_tokens   <= '0;
            r_bad_one  <= 1'b0;
            r_bad_two  <= 1'b0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_mask     <= n_mask;
            r_chosen   <= n_chosen;
            r_args_end <= n_args_end;
            r_inside   <= n_inside;
            r_tokens   <= n_tokens;
            r_bad_one  <= n_bad_one;
            r_bad_two  <= n_bad_two;
        end
    end

    `POP3CC_ASSERT_NEXT(a_clear_after_last, i_step && i_last_byte, r_pos == '0 && r_mask == MASK_ALL && r_chosen == CMD_NONE, "state not cleared after last byte")
    `POP3CC_ASSERT_NOW(a_chosen_after_keyword, r_chosen != CMD_NONE, r_pos >= 5'd4, "command chosen before any keyword could end")
    `POP3CC_ASSERT_NOW(a_end_needs_command, r_args_end, r_chosen != CMD_NONE, "argument end seen without a command")

endmodule

FILE: src/pop3_command_checker.sv
// Top level of the POP3 command checker: input register, result register and
// handshakes. Uses pop3cc_pkg, pop3cc_tracker and pop3_command_checker_macros.svh.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  input    | in        | i_valid / o_ready  | i_data_byte, i_last_byte
//  result   | out       | o_valid / i_ready  | o_command_code, o_verdict, o_token_count
//
// One byte is taken every clock unless a last byte waits on a stalled result;
// a result is offered once its last byte has passed the input register and
// been captured in the result register, which a full result slot can delay.
// A stalled result holds only the stage carrying a last byte; other bytes keep
// flowing. Reset (synchronous, active low) clears both valid flags and the
// per-message state; the state also clears itself after every last byte.
`include "pop3_command_checker_macros.svh"

module pop3_command_checker
    import pop3cc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_command_code,
    output logic [2:0] o_verdict,
    output logic [1:0] o_token_count
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_result;
    logic       out_free;
    logic       step_go;

    assign out_free = !r_out_valid || i_ready;
    // Advance the held byte unless it ends a message and the result slot is full and not being taken
    assign step_go  = r_in_valid && (!r_in_last || out_free);
    assign o_ready  = !r_in_valid || step_go;

    pop3cc_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step_go),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && r_in_last) begin
            r_out <= step_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command_code = r_out.command_code;
    assign o_verdict      = r_out.verdict;
    assign o_token_count  = r_out.token_count;

    `POP3CC_ASSERT_NEXT(a_last_gives_result, step_go && r_in_last, r_out_valid,
        "last byte processed without a result")
    `POP3CC_ASSERT_NEXT(a_taken_result_drains,
        r_out_valid && i_ready && !(r_in_valid && r_in_last), !r_out_valid,
        "result repeated after being taken")
    `POP3CC_ASSERT_NOW(a_verdict_needs_command, r_out_valid && r_out.verdict != VERD_OK,
        r_out.command_code != CMD_NONE, "verdict without a command")
    `POP3CC_ASSERT_NOW(a_count_needs_command, r_out_valid && r_out.token_count != 2'd0,
        r_out.command_code != CMD_NONE, "token count without a command")

endmodule
